### sv/chunked_serial_link_with_ack_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the chunked serial link core
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef CHUNKED_SERIAL_LINK_WITH_ACK_CORE_MACROS_SVH
`define CHUNKED_SERIAL_LINK_WITH_ACK_CORE_MACROS_SVH

// Property must hold at every edge outside reset
`define CSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be seen outside reset
`define CSL_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### sv/csl_pkg.sv
// ----------------------------------------------------------------------------
// csl_pkg
// Types and constants shared by the chunked serial link core.
// ----------------------------------------------------------------------------
package csl_pkg;

  // Fixed field widths
  localparam int BYTE_W    = 8;
  localparam int REM_W     = 17;  // header plus 16-bit length
  localparam int CFG_IDX_W = 1;

  // Command queue geometry
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'd1;

  // Reset values of the magic bytes
  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;

  // Acknowledge sequence
  localparam logic [BYTE_W-1:0] ACK_A_BYTE = 8'h41;
  localparam logic [BYTE_W-1:0] ACK_C_BYTE = 8'h43;
  localparam logic [BYTE_W-1:0] ACK_K_BYTE = 8'h4B;

  typedef enum logic [1:0] {
    KIND_TO_LINK = 2'd0,
    KIND_TO_HOST = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_REFUSED = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ACK_IDLE  = 2'd0,
    ACK_GOT_A = 2'd1,
    ACK_GOT_C = 2'd2
  } ack_e;

  typedef enum logic {
    CMD_SINGLE = 1'b0,
    CMD_CHUNK  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FETCH,
    BK_BYTE,
    BK_ACK_A,
    BK_ACK_C,
    BK_ACK_K,
    BK_DONE
  } back_state_e;

  // Work handed from front to back
  typedef struct packed {
    cmd_e              op;
    kind_e             kind;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  // Flags of the chunk being delivered
  typedef struct packed {
    logic first;  // chunk opens with the header window
    logic fin;    // chunk closes the message
  } chunk_info_t;

  // One result beat
  typedef struct packed {
    kind_e             kind;
    logic [BYTE_W-1:0] data;
    logic              last;
  } res_t;

endpackage

### sv/chunked_serial_link_with_ack_core.sv
// ----------------------------------------------------------------------------
// chunked_serial_link_with_ack_core
// Byte link endpoint: chunked receive with A-C-K per chunk, chunked transmit
// gated on the far end's A-C-K.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   in      | input     | in_valid_i/in_ready_o | func_i data_byte_i message_end_i
//   out     | output    | out_valid_o/ready_i   | kind_o out_byte_o run_last_o
//   cfg     | input     | cfg_valid_i/ready_o   | cfg_index_i cfg_data_i
//
// A beat with one result is held in the command queue, then in the output register.
// A chunk's bytes leave one at a time, each read from the chunk store's registered
// read port (FETCH then BYTE) before it is loaded; A, C and K follow, plus the
// completion result on a message's final chunk.
// in_ready_o is low from a chunk's last byte until its final result is loaded,
// and while the two-entry command queue is full. Output stalls back up into it.
// No clearing pass after reset; the configuration port is always ready.
// ----------------------------------------------------------------------------
module chunked_serial_link_with_ack_core
  import csl_pkg::*;
#(
  parameter int CHUNK_BYTES  = 16,
  parameter int HEADER_BYTES = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 func_i,
  input  logic [BYTE_W-1:0]    data_byte_i,
  input  logic                 message_end_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           kind_o,
  output logic [BYTE_W-1:0]    out_byte_o,
  output logic                 run_last_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BYTE_W-1:0]    cfg_data_i
);

  localparam int CNT_W = $clog2(CHUNK_BYTES + 1);
  localparam int IDX_W = $clog2(CHUNK_BYTES);

  logic                                q_push, q_pop, q_full, q_empty;
  cmd_t                                q_cmd_in, q_cmd_out;
  logic                                chunk_done;
  logic                                mem_we;
  logic [IDX_W-1:0]                    mem_waddr;
  logic [BYTE_W-1:0]                   mem_wdata;
  logic [HEADER_BYTES-1:0][BYTE_W-1:0] hdr;
  logic [CNT_W-1:0]                    chunk_len;
  chunk_info_t                         chunk_info;
  res_t                                result;

  assign cfg_ready_o = 1'b1;
  assign kind_o      = result.kind;
  assign out_byte_o  = result.data;
  assign run_last_o  = result.last;

  csl_front #(
    .CHUNK_BYTES (CHUNK_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .CNT_W       (CNT_W),
    .IDX_W       (IDX_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .data_byte_i  (data_byte_i),
    .message_end_i(message_end_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .q_push_o     (q_push),
    .q_cmd_o      (q_cmd_in),
    .q_full_i     (q_full),
    .chunk_done_i (chunk_done),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .hdr_o        (hdr),
    .chunk_len_o  (chunk_len),
    .chunk_info_o (chunk_info)
  );

  csl_cmd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_cmd_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .cmd_o  (q_cmd_out),
    .empty_o(q_empty)
  );

  csl_back #(
    .CHUNK_BYTES (CHUNK_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .CNT_W       (CNT_W),
    .IDX_W       (IDX_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_cmd_i     (q_cmd_out),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .mem_we_i    (mem_we),
    .mem_waddr_i (mem_waddr),
    .mem_wdata_i (mem_wdata),
    .hdr_i       (hdr),
    .chunk_len_i (chunk_len),
    .chunk_info_i(chunk_info),
    .chunk_done_o(chunk_done),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

endmodule

### sv/csl_cmd_queue.sv
// ----------------------------------------------------------------------------
// csl_cmd_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module csl_cmd_queue
  import csl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);

  cmd_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  // Pointer and count update
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### sv/csl_front.sv
// ----------------------------------------------------------------------------
// csl_front
// Accepts beats, keeps the receive, transmit and ack-match state and queues
// the work each beat causes.
// ----------------------------------------------------------------------------
`include "chunked_serial_link_with_ack_core_macros.svh"

module csl_front
  import csl_pkg::*;
#(
  parameter int CHUNK_BYTES  = 16,
  parameter int HEADER_BYTES = 5,
  parameter int CNT_W        = $clog2(CHUNK_BYTES + 1),
  parameter int IDX_W        = $clog2(CHUNK_BYTES)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                func_i,
  input  logic [BYTE_W-1:0]                   data_byte_i,
  input  logic                                message_end_i,
  // register writes
  input  logic                                cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]                cfg_index_i,
  input  logic [BYTE_W-1:0]                   cfg_data_i,
  // command queue
  output logic                                q_push_o,
  output cmd_t                                q_cmd_o,
  input  logic                                q_full_i,
  // chunk hand-off to back
  input  logic                                chunk_done_i,
  output logic                                mem_we_o,
  output logic [IDX_W-1:0]                    mem_waddr_o,
  output logic [BYTE_W-1:0]                   mem_wdata_o,
  output logic [HEADER_BYTES-1:0][BYTE_W-1:0] hdr_o,
  output logic [CNT_W-1:0]                    chunk_len_o,
  output chunk_info_t                         chunk_info_o
);

  logic [BYTE_W-1:0]                   sync_first_q, sync_second_q;
  logic [HEADER_BYTES-1:0][BYTE_W-1:0] hdr_q, hdr_d;
  logic [CNT_W-1:0]                    fill_q, fill_d;
  logic                                hdr_done_q, hdr_done_d;
  logic                                first_q, first_d;
  logic [REM_W-1:0]                    remain_q, remain_d;
  ack_e                                ack_q, ack_d;
  logic                                await_q, await_d;
  logic [CNT_W-1:0]                    send_cnt_q, send_cnt_d;
  logic                                pend_q, pend_d;
  logic [CNT_W-1:0]                    len_q, len_d;
  chunk_info_t                         info_q, info_d;

  logic [HEADER_BYTES-1:0][BYTE_W-1:0] win;
  logic [HEADER_BYTES-1:0][BYTE_W-1:0] win_shift;
  logic [CNT_W-1:0]                    fill_new;
  logic [REM_W-1:0]                    rem_src;
  logic [REM_W-1:0]                    rem_after;
  logic [CNT_W-1:0]                    want;
  logic                                check_chunk;
  logic                                first_now;
  logic                                accept;

  assign in_ready_o   = !q_full_i && !pend_q;
  assign accept       = in_valid_i && in_ready_o;
  assign hdr_o        = hdr_q;
  assign chunk_len_o  = len_q;
  assign chunk_info_o = info_q;
  assign mem_waddr_o  = fill_q[IDX_W-1:0];
  assign mem_wdata_o  = data_byte_i;
  assign fill_new     = fill_q + 1'b1;

  // Header window with the new byte placed, and its one-byte resync shift
  always_comb begin
    win = hdr_q;
    for (int i = 0; i < HEADER_BYTES; i++) begin
      if (fill_q == CNT_W'(i)) begin
        win[i] = data_byte_i;
      end
    end
    win_shift = win;
    for (int i = 0; i < HEADER_BYTES - 1; i++) begin
      win_shift[i] = win[i + 1];
    end
  end

  // Chunk size still owed: parsed length right at parse, else the running rest
  always_comb begin
    if (!hdr_done_q) begin
      rem_src = REM_W'(HEADER_BYTES) + REM_W'({win[4], win[3]});
    end else begin
      rem_src = remain_q;
    end
    if (rem_src < REM_W'(CHUNK_BYTES)) begin
      want = rem_src[CNT_W-1:0];
    end else begin
      want = CNT_W'(CHUNK_BYTES);
    end
    rem_after = rem_src - REM_W'(want);
  end

  // Per-beat state update and command generation
  always_comb begin
    hdr_d       = hdr_q;
    fill_d      = fill_q;
    hdr_done_d  = hdr_done_q;
    first_d     = first_q;
    remain_d    = remain_q;
    ack_d       = ack_q;
    await_d     = await_q;
    send_cnt_d  = send_cnt_q;
    pend_d      = pend_q && !chunk_done_i;
    len_d       = len_q;
    info_d      = info_q;
    q_push_o    = 1'b0;
    q_cmd_o     = '{op: CMD_SINGLE, kind: KIND_TO_LINK, data: data_byte_i};
    mem_we_o    = 1'b0;
    check_chunk = 1'b0;
    first_now   = first_q;

    if (accept) begin
      if (!func_i) begin
        if (await_q) begin
          // ack matcher, A always restarts
          if (ack_q == ACK_GOT_C && data_byte_i == ACK_K_BYTE) begin
            ack_d   = ACK_IDLE;
            await_d = 1'b0;
          end else if (ack_q == ACK_GOT_A && data_byte_i == ACK_C_BYTE) begin
            ack_d = ACK_GOT_C;
          end else if (data_byte_i == ACK_A_BYTE) begin
            ack_d = ACK_GOT_A;
          end else begin
            ack_d = ACK_IDLE;
          end
        end else if (!hdr_done_q) begin
          // header hunt
          if (fill_new < CNT_W'(HEADER_BYTES)) begin
            hdr_d  = win;
            fill_d = fill_new;
          end else if (win[0] != sync_first_q || win[1] != sync_second_q) begin
            hdr_d  = win_shift;
            fill_d = CNT_W'(HEADER_BYTES - 1);
          end else begin
            hdr_d       = win;
            fill_d      = fill_new;
            hdr_done_d  = 1'b1;
            first_now   = 1'b1;
            first_d     = 1'b1;
            remain_d    = rem_src;
            check_chunk = 1'b1;
          end
        end else begin
          // payload byte into the chunk store
          mem_we_o    = 1'b1;
          fill_d      = fill_new;
          check_chunk = 1'b1;
        end

        // full chunk: hand it to the back part
        if (check_chunk && fill_new >= want) begin
          q_push_o    = 1'b1;
          q_cmd_o.op  = CMD_CHUNK;
          pend_d      = 1'b1;
          len_d       = want;
          info_d      = '{first: first_now, fin: (rem_after == '0)};
          remain_d    = rem_after;
          fill_d      = '0;
          first_d     = 1'b0;
          if (rem_after == '0) begin
            hdr_done_d = 1'b0;
          end
        end
      end else if (await_q) begin
        q_push_o     = 1'b1;
        q_cmd_o.kind = KIND_REFUSED;
        q_cmd_o.data = '0;
      end else begin
        // host byte straight to the link
        q_push_o = 1'b1;
        if (send_cnt_q + 1'b1 == CNT_W'(CHUNK_BYTES) || message_end_i) begin
          await_d    = 1'b1;
          send_cnt_d = '0;
        end else begin
          send_cnt_d = send_cnt_q + 1'b1;
        end
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SYNC_FIRST_RST;
      sync_second_q <= SYNC_SECOND_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SYNC_FIRST:  sync_first_q  <= cfg_data_i;
        CFG_SYNC_SECOND: sync_second_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      hdr_done_q <= 1'b0;
      first_q    <= 1'b0;
      remain_q   <= '0;
      ack_q      <= ACK_IDLE;
      await_q    <= 1'b0;
      send_cnt_q <= '0;
      pend_q     <= 1'b0;
      len_q      <= '0;
      info_q     <= '0;
    end else begin
      fill_q     <= fill_d;
      hdr_done_q <= hdr_done_d;
      first_q    <= first_d;
      remain_q   <= remain_d;
      ack_q      <= ack_d;
      await_q    <= await_d;
      send_cnt_q <= send_cnt_d;
      pend_q     <= pend_d;
      len_q      <= len_d;
      info_q     <= info_d;
    end
  end

  // Header window bytes
  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
  end

  `CSL_ASSERT(a_hdr_fill_bound, !hdr_done_q |-> fill_q < CNT_W'(HEADER_BYTES), "header fill overrun")
  `CSL_ASSERT(a_chunk_marks_pend, (q_push_o && q_cmd_o.op == CMD_CHUNK) |=> pend_q, "chunk not held")
  `CSL_NEVER(a_push_full, q_push_o && q_full_i, "push into full queue")

endmodule

### sv/csl_back.sv
// ----------------------------------------------------------------------------
// csl_back
// Carries out queued commands: single results, and chunk delivery from the
// chunk store followed by A-C-K and the completion result.
// ----------------------------------------------------------------------------
`include "chunked_serial_link_with_ack_core_macros.svh"

module csl_back
  import csl_pkg::*;
#(
  parameter int CHUNK_BYTES  = 16,
  parameter int HEADER_BYTES = 5,
  parameter int CNT_W        = $clog2(CHUNK_BYTES + 1),
  parameter int IDX_W        = $clog2(CHUNK_BYTES)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command queue
  input  cmd_t                                q_cmd_i,
  input  logic                                q_empty_i,
  output logic                                q_pop_o,
  // chunk store write port and chunk context
  input  logic                                mem_we_i,
  input  logic [IDX_W-1:0]                    mem_waddr_i,
  input  logic [BYTE_W-1:0]                   mem_wdata_i,
  input  logic [HEADER_BYTES-1:0][BYTE_W-1:0] hdr_i,
  input  logic [CNT_W-1:0]                    chunk_len_i,
  input  chunk_info_t                         chunk_info_i,
  output logic                                chunk_done_o,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output res_t                                result_o
);

  logic [BYTE_W-1:0] mem [CHUNK_BYTES];
  logic [BYTE_W-1:0] rd_q;

  back_state_e       state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  res_t              out_q, out_d;
  logic              rd_en;
  logic              free;
  logic              hdr_hit;
  logic [BYTE_W-1:0] hdr_byte;
  logic [BYTE_W-1:0] byte_sel;

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;
  assign free        = !out_valid_q || out_ready_i;

  // Chunk store
  always_ff @(posedge clk_i) begin
    if (mem_we_i) begin
      mem[mem_waddr_i] <= mem_wdata_i;
    end
    if (rd_en) begin
      rd_q <= mem[idx_q];
    end
  end

  // Leading bytes of the first chunk come from the header window
  always_comb begin
    hdr_hit  = 1'b0;
    hdr_byte = '0;
    for (int i = 0; i < HEADER_BYTES; i++) begin
      if (idx_q == IDX_W'(i)) begin
        hdr_hit  = 1'b1;
        hdr_byte = hdr_i[i];
      end
    end
    byte_sel = (chunk_info_i.first && hdr_hit) ? hdr_byte : rd_q;
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    q_pop_o      = 1'b0;
    rd_en        = 1'b0;
    chunk_done_o = 1'b0;

    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          if (q_cmd_i.op == CMD_CHUNK) begin
            q_pop_o = 1'b1;
            idx_d   = '0;
            state_d = BK_FETCH;
          end else if (free) begin
            q_pop_o     = 1'b1;
            out_valid_d = 1'b1;
            out_d       = '{kind: q_cmd_i.kind, data: q_cmd_i.data, last: 1'b1};
          end
        end
      end
      BK_FETCH: begin
        rd_en   = 1'b1;
        state_d = BK_BYTE;
      end
      BK_BYTE: begin
        if (free) begin
          out_valid_d = 1'b1;
          out_d       = '{kind: KIND_TO_HOST, data: byte_sel, last: 1'b0};
          if (CNT_W'(idx_q) + 1'b1 == chunk_len_i) begin
            state_d = BK_ACK_A;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = BK_FETCH;
          end
        end
      end
      BK_ACK_A: begin
        if (free) begin
          out_valid_d = 1'b1;
          out_d       = '{kind: KIND_TO_LINK, data: ACK_A_BYTE, last: 1'b0};
          state_d     = BK_ACK_C;
        end
      end
      BK_ACK_C: begin
        if (free) begin
          out_valid_d = 1'b1;
          out_d       = '{kind: KIND_TO_LINK, data: ACK_C_BYTE, last: 1'b0};
          state_d     = BK_ACK_K;
        end
      end
      BK_ACK_K: begin
        if (free) begin
          out_valid_d = 1'b1;
          out_d       = '{kind: KIND_TO_LINK, data: ACK_K_BYTE, last: !chunk_info_i.fin};
          if (chunk_info_i.fin) begin
            state_d = BK_DONE;
          end else begin
            chunk_done_o = 1'b1;
            state_d      = BK_IDLE;
          end
        end
      end
      BK_DONE: begin
        if (free) begin
          out_valid_d  = 1'b1;
          out_d        = '{kind: KIND_DONE, data: '0, last: 1'b1};
          chunk_done_o = 1'b1;
          state_d      = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  `CSL_ASSERT(a_done_leaves_beat, chunk_done_o |=> out_valid_q, "chunk end without result")
  `CSL_ASSERT(a_idx_in_chunk, (state_q == BK_FETCH || state_q == BK_BYTE) |-> CNT_W'(idx_q) < chunk_len_i, "chunk index past length")
  `CSL_NEVER(a_pop_empty, q_pop_o && q_empty_i, "pop from empty queue")

endmodule

### bench/tb_chunked_serial_link_with_ack_core.sv
// ----------------------------------------------------------------------------
// tb_chunked_serial_link_with_ack_core
// Self-checking bench for the chunked serial link endpoint. A queue-fed driver
// offers link and host bytes, a clocked monitor compares every output beat
// against an in-bench model of the receive window, chunk delivery, transmit
// chunking and the A-C-K matcher. Runs directed cases, then randomized
// messages under several magic-byte settings, with random idling and one
// long output hold-off.
// ----------------------------------------------------------------------------
module tb_chunked_serial_link_with_ack_core
  import csl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  CHUNK       = 16;
  localparam int  HDR         = 5;
  localparam int  IDLE_PCT    = 13;
  localparam int  HOLD_CYCLES = 300;
  localparam int  DRAIN       = 2 * CHUNK + 3 + 1 + 8;
  localparam int  LIMIT_NS    = 2_000_000;
  localparam logic FROM_LINK  = 1'b0;
  localparam logic FROM_HOST  = 1'b1;

  typedef struct packed {
    logic              func;
    logic [BYTE_W-1:0] data;
    logic              mend;
  } link_item_t;

  // DUT signals, inputs all known from time zero
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_ready_o;
  logic                 func_i        = 1'b0;
  logic [BYTE_W-1:0]    data_byte_i   = '0;
  logic                 message_end_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i   = 1'b0;
  logic [1:0]           kind_o;
  logic [BYTE_W-1:0]    out_byte_o;
  logic                 run_last_o;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [BYTE_W-1:0]    cfg_data_i    = '0;

  // Bench bookkeeping
  link_item_t byte_feed[$];
  res_t       due_beats[$];
  link_item_t cur_item;
  res_t       want_beat;
  int         errors   = 0;
  int         queued   = 0;
  int         tx_gen   = 0;
  bit         calm     = 1'b0;
  int         hold_seq = 0;
  int         hold_seen = 0;
  int         hold_left = 0;

  // Model state
  logic [BYTE_W-1:0] magic0 = SYNC_FIRST_RST;
  logic [BYTE_W-1:0] magic1 = SYNC_SECOND_RST;
  logic [BYTE_W-1:0] rx_buf [CHUNK];
  logic [4:0]        rx_fill   = '0;
  logic [REM_W-1:0]  msg_total = '0;
  logic [REM_W-1:0]  delivered = '0;
  ack_e              ack_st    = ACK_IDLE;
  bit                tx_wait   = 1'b0;
  logic [4:0]        tx_count  = '0;
  bit                tx_fin    = 1'b0;

  chunked_serial_link_with_ack_core #(
    .CHUNK_BYTES (CHUNK),
    .HEADER_BYTES(HDR)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .data_byte_i  (data_byte_i),
    .message_end_i(message_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic res_t beat_of(kind_e k, logic [BYTE_W-1:0] d);
    res_t r;
    r.kind = k;
    r.data = d;
    r.last = 1'b0;
    return r;
  endfunction

  // Expected output beats for one accepted input beat
  function automatic void beats_for_item(link_item_t it);
    res_t             burst[$];
    res_t             tail;
    logic [REM_W-1:0] left;
    logic [REM_W-1:0] want;
    bit               deliver;
    deliver = 1'b0;
    if (it.func == FROM_LINK) begin
      if (tx_wait) begin
        // A-C-K matcher; 'A' always restarts
        if (ack_st == ACK_GOT_C && it.data == ACK_K_BYTE) begin
          ack_st  = ACK_IDLE;
          tx_wait = 1'b0;
          tx_fin  = 1'b0;
        end else if (ack_st == ACK_GOT_A && it.data == ACK_C_BYTE) begin
          ack_st = ACK_GOT_C;
        end else if (it.data == ACK_A_BYTE) begin
          ack_st = ACK_GOT_A;
        end else begin
          ack_st = ACK_IDLE;
        end
      end else begin
        if (rx_fill < CHUNK) rx_buf[rx_fill] = it.data;
        rx_fill++;
        deliver = 1'b1;
        // header window: slide until the magic bytes lead
        if (msg_total == '0) begin
          if (rx_fill < HDR) begin
            deliver = 1'b0;
          end else if (rx_buf[0] != magic0 || rx_buf[1] != magic1) begin
            for (int i = 0; i < HDR - 1; i++) rx_buf[i] = rx_buf[i+1];
            rx_fill = HDR - 1;
            deliver = 1'b0;
          end else begin
            msg_total = HDR + {rx_buf[4], rx_buf[3]};
            delivered = '0;
          end
        end
        // full chunk: bytes to host, ACK to link, maybe completion
        if (deliver) begin
          left = msg_total - delivered;
          want = (left < CHUNK) ? left : CHUNK;
          if (rx_fill >= want) begin
            for (int i = 0; i < want; i++) begin
              burst.insert(burst.size(), beat_of(KIND_TO_HOST, rx_buf[i]));
            end
            burst.insert(burst.size(), beat_of(KIND_TO_LINK, ACK_A_BYTE));
            burst.insert(burst.size(), beat_of(KIND_TO_LINK, ACK_C_BYTE));
            burst.insert(burst.size(), beat_of(KIND_TO_LINK, ACK_K_BYTE));
            delivered = delivered + want;
            rx_fill   = '0;
            if (delivered >= msg_total) begin
              burst.insert(burst.size(), beat_of(KIND_DONE, '0));
              msg_total = '0;
              delivered = '0;
            end
          end
        end
      end
    end else if (tx_wait) begin
      burst.insert(burst.size(), beat_of(KIND_REFUSED, '0));
    end else begin
      burst.insert(burst.size(), beat_of(KIND_TO_LINK, it.data));
      tx_count++;
      if (tx_count >= CHUNK || it.mend) begin
        tx_wait  = 1'b1;
        tx_fin   = it.mend;
        tx_count = '0;
      end
    end
    if (burst.size() != 0) begin
      tail      = burst.pop_back();
      tail.last = 1'b1;
      burst.insert(burst.size(), tail);
    end
    foreach (burst[i]) due_beats.insert(due_beats.size(), burst[i]);
  endfunction

  // Input driver: valid held until accepted, random idle between beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) beats_for_item(cur_item);
      if (!in_valid_i || in_ready_o) begin
        if (byte_feed.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          cur_item       = byte_feed.pop_front();
          in_valid_i    <= 1'b1;
          func_i        <= cur_item.func;
          data_byte_i   <= cur_item.data;
          message_end_i <= cur_item.mend;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compare beats, random stalls, one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (due_beats.size() == 0) begin
          $display("%0t: unexpected beat: expected none, actual kind=%0d byte=%h last=%0d",
                   $time, kind_o, out_byte_o, run_last_o);
          errors++;
        end else begin
          want_beat = due_beats.pop_front();
          if (kind_o !== want_beat.kind) begin
            $display("%0t: kind mismatch: expected %0d, actual %0d",
                     $time, want_beat.kind, kind_o);
            errors++;
          end
          if (out_byte_o !== want_beat.data) begin
            $display("%0t: out_byte mismatch: expected %h, actual %h",
                     $time, want_beat.data, out_byte_o);
            errors++;
          end
          if (run_last_o !== want_beat.last) begin
            $display("%0t: run_last mismatch: expected %0d, actual %0d",
                     $time, want_beat.last, run_last_o);
            errors++;
          end
        end
      end
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic queue_item(logic func, logic [BYTE_W-1:0] data, logic mend);
    link_item_t it;
    it.func = func;
    it.data = data;
    it.mend = mend;
    byte_feed.insert(byte_feed.size(), it);
    queued++;
  endtask

  task automatic link_byte(logic [BYTE_W-1:0] data);
    queue_item(FROM_LINK, data, 1'($urandom_range(1)));
  endtask

  // Register write, only called while the block is idle
  task automatic write_magic(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_SYNC_FIRST) magic0 = val;
    else                       magic1 = val;
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Wait until all beats are accepted and all results are back
  task automatic wait_drain();
    while (byte_feed.size() != 0 || in_valid_i || due_beats.size() != 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
  endtask

  function automatic logic [BYTE_W-1:0] noise_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(255)); while (b == magic0);
    return b;
  endfunction

  // Well-formed received message: header then payload
  task automatic gen_rx_msg(int len);
    logic [15:0] l16;
    l16 = 16'(len);
    link_byte(magic0);
    link_byte(magic1);
    link_byte(BYTE_W'($urandom_range(255)));
    link_byte(l16[7:0]);
    link_byte(l16[15:8]);
    repeat (len) link_byte(BYTE_W'($urandom_range(255)));
  endtask

  // Outgoing message, each chunk closed by an A-C-K from the far end
  task automatic gen_tx_msg(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      queue_item(FROM_HOST, BYTE_W'($urandom_range(255)), i == n - 1);
      tx_gen++;
      if (tx_gen == CHUNK || i == n - 1) begin
        tx_gen = 0;
        r = $urandom_range(9);
        if (r == 5) begin
          repeat ($urandom_range(1, 3))
            queue_item(FROM_HOST, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
        end
        if (r == 6) link_byte(noise_byte());
        if (r == 7) link_byte(ACK_A_BYTE);
        if (r >= 8) begin
          link_byte(ACK_A_BYTE);
          link_byte(ACK_C_BYTE);
          if (r == 9) link_byte(8'h00);
        end
        link_byte(ACK_A_BYTE);
        link_byte(ACK_C_BYTE);
        link_byte(ACK_K_BYTE);
      end
    end
  endtask

  task automatic random_phase(int count);
    int r;
    int target;
    target = queued + count;
    while (queued < target) begin
      r = $urandom_range(99);
      if (r < 35) begin
        r = $urandom_range(99);
        if (r < 10)      gen_rx_msg(($urandom_range(1) != 0) ? CHUNK - HDR : 2 * CHUNK - HDR);
        else if (r < 25) gen_rx_msg($urandom_range(28, 90));
        else             gen_rx_msg($urandom_range(0, 27));
      end else if (r < 70) begin
        gen_tx_msg($urandom_range(1, 36));
      end else if (r < 80) begin
        repeat ($urandom_range(1, 4)) link_byte(noise_byte());
      end else if (r < 90) begin
        // broken header: first magic byte, wrong second
        link_byte(magic0);
        do r = $urandom_range(255); while (r == magic0 || r == magic1);
        link_byte(BYTE_W'(r));
        repeat (3) link_byte(noise_byte());
      end else begin
        // stray first magic byte before a real header forces a slide
        link_byte(magic0);
        gen_rx_msg($urandom_range(0, 20));
      end
    end
  endtask

  // Stimulus sequence
  initial begin
    logic [BYTE_W-1:0] m0;
    logic [BYTE_W-1:0] m1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: slide, zero-length message, one-byte payload
    queue_item(FROM_LINK, 8'h12, 1'b0);
    queue_item(FROM_LINK, SYNC_FIRST_RST, 1'b1);
    queue_item(FROM_LINK, SYNC_SECOND_RST, 1'b0);
    queue_item(FROM_LINK, 8'h07, 1'b1);
    queue_item(FROM_LINK, 8'h00, 1'b0);
    queue_item(FROM_LINK, 8'h00, 1'b1);
    queue_item(FROM_LINK, SYNC_FIRST_RST, 1'b0);
    queue_item(FROM_LINK, SYNC_SECOND_RST, 1'b0);
    queue_item(FROM_LINK, 8'hFF, 1'b0);
    queue_item(FROM_LINK, 8'h01, 1'b0);
    queue_item(FROM_LINK, 8'h00, 1'b0);
    queue_item(FROM_LINK, 8'hFF, 1'b1);
    // short message out, then a refused byte while waiting
    queue_item(FROM_HOST, 8'h00, 1'b0);
    queue_item(FROM_HOST, 8'hFF, 1'b1);
    queue_item(FROM_HOST, 8'h5A, 1'b1);
    // matcher: repeated A restarts, wrong byte drops to idle
    queue_item(FROM_LINK, ACK_A_BYTE, 1'b0);
    queue_item(FROM_LINK, ACK_A_BYTE, 1'b1);
    queue_item(FROM_LINK, ACK_C_BYTE, 1'b0);
    queue_item(FROM_LINK, 8'h00, 1'b0);
    queue_item(FROM_LINK, ACK_A_BYTE, 1'b0);
    queue_item(FROM_LINK, ACK_C_BYTE, 1'b0);
    queue_item(FROM_LINK, ACK_K_BYTE, 1'b1);
    wait_drain();

    // Magic bytes at the extremes
    write_magic(CFG_SYNC_FIRST, 8'h00);
    write_magic(CFG_SYNC_SECOND, 8'hFF);
    random_phase(110);
    wait_drain();

    // Swapped extremes, no idling on either side
    write_magic(CFG_SYNC_FIRST, 8'hFF);
    write_magic(CFG_SYNC_SECOND, 8'h00);
    calm = 1'b1;
    random_phase(110);
    wait_drain();
    calm = 1'b0;

    // Random magic bytes, output held off so the input backs up
    m0 = BYTE_W'($urandom_range(255));
    do m1 = BYTE_W'($urandom_range(255)); while (m1 == m0);
    write_magic(CFG_SYNC_FIRST, m0);
    write_magic(CFG_SYNC_SECOND, m1);
    random_phase(110);
    hold_seq++;
    wait_drain();

    // Back to the reset values
    write_magic(CFG_SYNC_FIRST, SYNC_FIRST_RST);
    write_magic(CFG_SYNC_SECOND, SYNC_SECOND_RST);
    random_phase(110);
    wait_drain();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
